### hdl/lse_pkg.sv
// ----------------------------------------------------------------------------
// lse_pkg
// Shared constants for the Legendre symbol (Euler criterion) block.
// ----------------------------------------------------------------------------
package lse_pkg;

    localparam int VALUE_BITS_DEF = 16;
    localparam int MODULUS_RESET  = 13;

    // symbol codes, two's complement
    localparam logic [1:0] SYM_ZERO = 2'b00;
    localparam logic [1:0] SYM_POS  = 2'b01;
    localparam logic [1:0] SYM_NEG  = 2'b11;

endpackage

### hdl/lse_in_if.sv
// ----------------------------------------------------------------------------
// lse_in_if
// Input stream: one signed value per transaction.
// ----------------------------------------------------------------------------
interface lse_in_if #(parameter int VALUE_BITS = lse_pkg::VALUE_BITS_DEF);
    logic                     valid;
    logic                     ready;
    logic signed [VALUE_BITS:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

### hdl/lse_out_if.sv
// ----------------------------------------------------------------------------
// lse_out_if
// Output stream: one symbol per transaction.
// ----------------------------------------------------------------------------
interface lse_out_if;
    logic              valid;
    logic              ready;
    logic signed [1:0] symbol;

    modport source (output valid, output symbol, input ready);
    modport sink   (input valid, input symbol, output ready);
endinterface

### hdl/lse_cell.sv
// ----------------------------------------------------------------------------
// lse_cell
// One bit step of a modular multiply: acc = (2*acc + y_msb*x) mod q.
// ----------------------------------------------------------------------------
module lse_cell #(
    parameter int VALUE_BITS = lse_pkg::VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic [VALUE_BITS-1:0] q,
    input  logic                  v_in,
    input  logic [VALUE_BITS-1:0] acc_in,
    input  logic [VALUE_BITS-1:0] x_in,
    input  logic [VALUE_BITS:0]   y_in,
    input  logic [VALUE_BITS-1:0] base_in,
    output logic                  v_reg,
    output logic [VALUE_BITS-1:0] acc_reg,
    output logic [VALUE_BITS-1:0] x_reg,
    output logic [VALUE_BITS:0]   y_reg,
    output logic [VALUE_BITS-1:0] base_reg
);

    localparam int W = VALUE_BITS;

    logic [W+1:0] sum;
    logic [W+1:0] q_ext;
    logic [W+1:0] t1;
    logic [W+1:0] t2;
    logic [W-1:0] acc_next;

    // acc, x below q, so the sum stays under 3q: at most two subtractions
    always_comb
    begin
        q_ext    = {2'b00, q};
        sum      = {1'b0, acc_in, 1'b0} + (y_in[W] ? {2'b00, x_in} : '0);
        t1       = (sum >= q_ext) ? (sum - q_ext) : sum;
        t2       = (t1 >= q_ext) ? (t1 - q_ext) : t1;
        acc_next = t2[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            acc_reg  <= acc_next;
            x_reg    <= x_in;
            y_reg    <= {y_in[W-1:0], 1'b0};
            base_reg <= base_in;
        end
    end

endmodule

### hdl/legendre_symbol_euler.sv
// Path: a row of one-bit modular multiply cells that reduces the input, the sign
// fix-up register, the square-and-multiply rows of cells, then the output register.
// Throughput: one transaction per cycle; the whole chain stalls only while a
// result waits in the output register.
// Reset: modulus returns to 13, the pipeline empties; no clearing pass.
// ----------------------------------------------------------------------------
// legendre_symbol_euler
// Legendre symbol by Euler's criterion: input reduction then left-to-right
// square-and-multiply, every multiply a row of bit-step cells.
// ----------------------------------------------------------------------------
module legendre_symbol_euler #(
    parameter int VALUE_BITS = lse_pkg::VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  modulus_we,
    input  logic [VALUE_BITS-1:0] modulus_wdata,
    lse_in_if.sink                item,
    lse_out_if.source             result
);

    import lse_pkg::*;

    localparam int W     = VALUE_BITS;
    localparam int NCELL = W + 1;
    localparam int NGRP  = 2 * W - 1;
    localparam logic [W-1:0]   Q_RST = W'(MODULUS_RESET);
    localparam logic [W-2:0]   E_RST = (W-1)'((MODULUS_RESET - 1) / 2);
    localparam logic [W-1:0]   ONE   = W'(1);

    logic [W-1:0] q_reg;
    logic [W-2:0] e_reg;
    logic [W-2:0] e_next;
    logic         adv;

    logic         v_c    [NGRP][NCELL];
    logic [W-1:0] acc_c  [NGRP][NCELL];
    logic [W-1:0] x_c    [NGRP][NCELL];
    logic [W:0]   y_c    [NGRP][NCELL];
    logic [W-1:0] base_c [NGRP][NCELL];

    logic         v_fix_reg;
    logic [W-1:0] base_fix_reg;
    logic [W-1:0] base_fix_next;
    logic         out_v_reg;
    logic [1:0]   sym_reg;
    logic [1:0]   sym_next;

    logic         neg;
    logic [W:0]   mag;

    // ---- configuration ----
    always_comb
    begin
        e_next = modulus_wdata[0] ? modulus_wdata[W-1:1] : (modulus_wdata[W-1:1] - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= Q_RST;
            e_reg <= E_RST;
        end
        else if (modulus_we)
        begin
            q_reg <= modulus_wdata;
            e_reg <= e_next;
        end
    end

    assign adv        = !out_v_reg || result.ready;
    assign item.ready = adv;

    assign neg = item.value[W];
    assign mag = neg ? (~item.value + 1'b1) : item.value;

    // ---- cell rows ----
    genvar g, c;
    generate
        for (g = 0; g < NGRP; g++)
        begin : g_grp
            logic         v_s;
            logic [W-1:0] x_s;
            logic [W:0]   y_s;
            logic [W-1:0] base_s;

            if (g == 0)
            begin : g_red
                // remainder of the magnitude; sign rides in the base field
                assign v_s    = item.valid;
                assign x_s    = ONE;
                assign y_s    = mag;
                assign base_s = {{(W-1){1'b0}}, neg};
            end
            else
            begin : g_exp
                localparam int EB = (W - 2) - (g - 1) / 2;
                logic [W-1:0] r_s;

                if (g == 1)
                begin : g_first
                    assign r_s    = ONE;
                    assign v_s    = v_fix_reg;
                    assign base_s = base_fix_reg;
                end
                else
                begin : g_next
                    assign r_s    = acc_c[g-1][NCELL-1];
                    assign v_s    = v_c[g-1][NCELL-1];
                    assign base_s = base_c[g-1][NCELL-1];
                end

                assign y_s = {1'b0, r_s};
                if (((g - 1) % 2) == 0)
                begin : g_sq
                    assign x_s = r_s;
                end
                else
                begin : g_mul
                    // multiply by one when the exponent bit is clear
                    assign x_s = e_reg[EB] ? base_s : ONE;
                end
            end

            for (c = 0; c < NCELL; c++)
            begin : g_cell
                if (c == 0)
                begin : g_head
                    lse_cell #(.VALUE_BITS(W)) u_cell (
                        .clk      (clk),
                        .rst_n    (rst_n),
                        .adv      (adv),
                        .q        (q_reg),
                        .v_in     (v_s),
                        .acc_in   ('0),
                        .x_in     (x_s),
                        .y_in     (y_s),
                        .base_in  (base_s),
                        .v_reg    (v_c[g][c]),
                        .acc_reg  (acc_c[g][c]),
                        .x_reg    (x_c[g][c]),
                        .y_reg    (y_c[g][c]),
                        .base_reg (base_c[g][c])
                    );
                end
                else
                begin : g_body
                    lse_cell #(.VALUE_BITS(W)) u_cell (
                        .clk      (clk),
                        .rst_n    (rst_n),
                        .adv      (adv),
                        .q        (q_reg),
                        .v_in     (v_c[g][c-1]),
                        .acc_in   (acc_c[g][c-1]),
                        .x_in     (x_c[g][c-1]),
                        .y_in     (y_c[g][c-1]),
                        .base_in  (base_c[g][c-1]),
                        .v_reg    (v_c[g][c]),
                        .acc_reg  (acc_c[g][c]),
                        .x_reg    (x_c[g][c]),
                        .y_reg    (y_c[g][c]),
                        .base_reg (base_c[g][c])
                    );
                end
            end
        end
    endgenerate

    // ---- sign fix-up: least nonnegative residue ----
    always_comb
    begin
        if (base_c[0][NCELL-1][0] && (acc_c[0][NCELL-1] != '0))
        begin
            base_fix_next = q_reg - acc_c[0][NCELL-1];
        end
        else
        begin
            base_fix_next = acc_c[0][NCELL-1];
        end
    end

    // ---- symbol decision ----
    always_comb
    begin
        if ((q_reg == '0) || (base_c[NGRP-1][NCELL-1] == '0))
        begin
            sym_next = SYM_ZERO;
        end
        else if (acc_c[NGRP-1][NCELL-1] == ONE)
        begin
            sym_next = SYM_POS;
        end
        else
        begin
            sym_next = SYM_NEG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_fix_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_fix_reg <= v_c[0][NCELL-1];
            out_v_reg <= v_c[NGRP-1][NCELL-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            base_fix_reg <= base_fix_next;
            sym_reg      <= sym_next;
        end
    end

    assign result.valid  = out_v_reg;
    assign result.symbol = sym_reg;

`ifndef NO_ASSERTIONS
    a_stall_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> (result.valid && !result.ready))
        else $error("input stalled without a waiting result");

    a_residue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (v_fix_reg && (q_reg != '0)) |-> (base_fix_reg < q_reg))
        else $error("reduced value not below modulus");

    a_exponent_odd_q: assert property (@(posedge clk) disable iff (!rst_n)
        q_reg[0] |-> (e_reg == q_reg[W-1:1]))
        else $error("exponent out of step with modulus");
`endif

endmodule

### sim/tb_legendre_symbol_euler.sv
// ----------------------------------------------------------------------------
// tb_legendre_symbol_euler
// Self-checking bench for the Euler-criterion Legendre symbol block. Values
// go in as valid/ready transactions and each symbol is checked in order
// against a local prediction. Directed corners and random traffic are run
// under several moduli, with idling on the input and stalls on the output.
// ----------------------------------------------------------------------------
module tb_legendre_symbol_euler;
    timeunit 1ns;
    timeprecision 1ps;
    import lse_pkg::*;

    localparam int VB          = 16;
    localparam int DRAIN_WAIT  = 600;    // a little over the pipeline depth
    localparam int STALL_LIMIT = 40000;

    logic clk;
    logic rst_n;
    logic modulus_we;
    logic [VB-1:0] modulus_wdata;

    lse_in_if #(.VALUE_BITS(VB)) item_if ();
    lse_out_if                   result_if ();

    legendre_symbol_euler #(.VALUE_BITS(VB)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .modulus_we    (modulus_we),
        .modulus_wdata (modulus_wdata),
        .item          (item_if),
        .result        (result_if)
    );

    logic [VB-1:0] cur_modulus;
    logic [1:0]    symbol_fifo[$];
    int            idle_pct;
    int            stall_pct;
    int            mismatches = 0;
    int            quiet_cycles = 0;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // symbol of a 17-bit two's complement value modulo q
    function automatic logic [1:0] legendre_of(logic [VB:0] raw, logic [VB-1:0] q);
        longint unsigned qq, mag, rem, a, r, b, e;
        qq = q;
        if (qq == 0)
            return SYM_ZERO;
        if (raw[VB])
        begin
            mag = (longint'(1) << (VB + 1)) - raw;
            rem = mag % qq;
            a = (rem == 0) ? 0 : qq - rem;
        end
        else
            a = raw % qq;
        if (a == 0)
            return SYM_ZERO;
        e = (qq - 1) / 2;
        r = 1 % qq;
        b = a;
        while (e != 0)
        begin
            if (e[0])
                r = (r * b) % qq;
            b = (b * b) % qq;
            e = e >> 1;
        end
        return (r == 1) ? SYM_POS : SYM_NEG;
    endfunction

    task automatic send_value(logic [VB:0] v);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(99) < idle_pct)
                item_if.valid <= 1'b0;
            else
                break;
        end
        item_if.valid <= 1'b1;
        item_if.value <= v;
        do
            @(posedge clk);
        while (!item_if.ready);
        symbol_fifo = {symbol_fifo, legendre_of(v, cur_modulus)};
    endtask

    task automatic wait_drained();
        @(negedge clk);
        item_if.valid <= 1'b0;
        while (symbol_fifo.size() != 0)
            @(posedge clk);
    endtask

    // only while idle: drain, let the pipeline empty, then write
    task automatic set_modulus(logic [VB-1:0] q);
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        @(negedge clk);
        modulus_we    <= 1'b1;
        modulus_wdata <= q;
        @(negedge clk);
        modulus_we    <= 1'b0;
        cur_modulus = q;
    endtask

    function automatic logic [VB:0] pick_value();
        logic [VB:0] v;
        int unsigned k;
        case ($urandom_range(4))
            0: v = 17'($urandom);
            1: v = 17'($urandom_range(40)) - 17'd20;
            2:
            begin
                k = $urandom_range(8);
                v = 17'((cur_modulus * k) & 17'h1ffff);
                if ($urandom_range(1))
                    v = -v;
            end
            3: v = 17'(cur_modulus + $urandom_range(2) - 1);
            default: v = 17'($urandom_range(65535));
        endcase
        return v;
    endfunction

    task automatic test_directed_corners();
        logic [VB:0] corners[$];
        corners = '{17'h00000, 17'h00001, 17'h1ffff, 17'h0ffff, 17'h10000, 17'h10001,
                    17'd13, -17'sd13, 17'd26, 17'd2, 17'd3, -17'sd3, 17'd12, 17'd4};
        idle_pct  = 0;
        stall_pct = 0;
        foreach (corners[i])
            send_value(corners[i]);
    endtask

    task automatic test_modulus_extremes();
        logic [VB-1:0] mods[$];
        mods = '{16'd3, 16'd65535, 16'd65521, 16'd0, 16'd1, 16'd2, 16'd4, 16'd9};
        foreach (mods[m])
        begin
            set_modulus(mods[m]);
            send_value(17'h00000);
            send_value(17'h1ffff);
            send_value(17'h10000);
            send_value(17'h0ffff);
            send_value({1'b0, mods[m]});
            repeat (4) send_value(pick_value());
        end
    endtask

    task automatic test_random_traffic();
        logic [VB-1:0] primes[$];
        int idles[4];
        int stalls[4];
        primes = '{16'd3, 16'd5, 16'd7, 16'd13, 16'd17, 16'd101, 16'd251,
                   16'd7919, 16'd32749, 16'd65521};
        idles  = '{0, 67, 0, 29};
        stalls = '{0, 0, 67, 29};
        for (int ph = 0; ph < 4; ph++)
        begin
            for (int s = 0; s < 3; s++)
            begin
                if ($urandom_range(3) == 0)
                    set_modulus(16'($urandom));
                else
                    set_modulus(primes[$urandom_range(primes.size() - 1)]);
                idle_pct  = idles[ph];
                stall_pct = stalls[ph];
                for (int n = 0; n < 70; n++)
                begin
                    send_value(pick_value());
                    // bursts with no idling at all
                    if (n == 35)
                    begin
                        idle_pct  = 0;
                        stall_pct = 0;
                    end
                    if (n == 50)
                    begin
                        idle_pct  = idles[ph];
                        stall_pct = stalls[ph];
                    end
                end
            end
        end
    endtask

    task automatic test_pause_until_drained();
        idle_pct  = 0;
        stall_pct = 29;
        repeat (20) send_value(pick_value());
        wait_drained();
        repeat (20) send_value(pick_value());
    endtask

    always @(negedge clk)
        result_if.ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        logic [1:0] want;
        if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (symbol_fifo.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected symbol %b", result_if.symbol);
            end
            else
            begin
                want = symbol_fifo.pop_front();
                if (result_if.symbol !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("symbol mismatch: expected %b actual %b",
                                 want, result_if.symbol);
                end
            end
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        modulus_we      = 1'b0;
        modulus_wdata   = '0;
        item_if.valid   = 1'b0;
        item_if.value   = '0;
        cur_modulus     = MODULUS_RESET;
        idle_pct        = 0;
        stall_pct       = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        test_directed_corners();
        test_modulus_extremes();
        test_pause_until_drained();
        test_random_traffic();

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
